// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Command, status and cell operation codes shared by the deque cell row and
// its control logic.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef enum logic [2:0] {
    CMD_PEEK       = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // what a cell does with one of its two words in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_SHIFT_IN  = 2'd1,
    CELL_SHIFT_OUT = 2'd2,
    CELL_LOAD      = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t a_op;
    cell_op_t b_op;
  } cell_ctrl_t;

  localparam int unsigned OUT_W = 32;

endpackage

// ===== src/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// One position of the deque row. Word a belongs to the front-aligned copy,
// word b to the back-aligned copy; each shifts, loads or holds.
// ----------------------------------------------------------------------------
module deq_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 11,
  parameter int unsigned INDEX      = 0
) (
  input  logic                    clk,
  input  deq_pkg::cell_ctrl_t     ctrl,
  input  logic [CNT_W-1:0]        count,
  input  logic [DATA_WIDTH-1:0]   word,
  input  logic [DATA_WIDTH-1:0]   a_left,
  input  logic [DATA_WIDTH-1:0]   a_right,
  input  logic [DATA_WIDTH-1:0]   b_left,
  input  logic [DATA_WIDTH-1:0]   b_right,
  output logic [DATA_WIDTH-1:0]   a_q,
  output logic [DATA_WIDTH-1:0]   b_q,
  output logic [DATA_WIDTH-1:0]   a_nxt,
  output logic [DATA_WIDTH-1:0]   b_nxt
);
  import deq_pkg::*;

  logic [DATA_WIDTH-1:0] a_r;
  logic [DATA_WIDTH-1:0] b_r;
  logic                  hit;

  // the first free position takes a load
  assign hit = (count == CNT_W'(INDEX));

  always_comb begin
    case (ctrl.a_op)
      CELL_HOLD:      a_nxt = a_r;
      CELL_SHIFT_IN:  a_nxt = a_left;
      CELL_SHIFT_OUT: a_nxt = a_right;
      CELL_LOAD:      a_nxt = hit ? word : a_r;
      default:        a_nxt = a_r;
    endcase
  end

  always_comb begin
    case (ctrl.b_op)
      CELL_HOLD:      b_nxt = b_r;
      CELL_SHIFT_IN:  b_nxt = b_left;
      CELL_SHIFT_OUT: b_nxt = b_right;
      CELL_LOAD:      b_nxt = hit ? word : b_r;
      default:        b_nxt = b_r;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign a_q = a_r;
  assign b_q = b_r;

endmodule

// ===== src/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of DEPTH words kept in a row of cells, front-aligned and
// back-aligned copies side by side, with a registered result stage.
// ----------------------------------------------------------------------------
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid in_ready in_cmd in_push_value    | to unit
//   out      | out_valid out_ready and five result ports | from unit
//
// one command per cycle; the result is registered at the transfer edge and is
// valid in the following cycle. every cell updates in that same cycle, so a
// new command can follow each cycle while out_ready is high.
// rst_n clears the element count and the output valid; cell words are not
// reset. a waiting result does not block a new transfer when out_ready is high.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_cmd,
  input  logic signed [deq_pkg::OUT_W-1:0] in_push_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [deq_pkg::OUT_W-1:0] out_front_value,
  output logic signed [deq_pkg::OUT_W-1:0] out_back_value,
  output logic [CNT_W-1:0]             out_count,
  output logic                         out_is_empty,
  output logic [1:0]                   out_status
);
  import deq_pkg::*;

  cell_ctrl_t            ctrl;
  logic                  fire;
  logic                  full;
  logic                  empty;
  logic                  have_pop;
  status_t               status;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic [2*OUT_W-1:0]    push_wide;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] popped;

  logic [DATA_WIDTH-1:0] a_q   [DEPTH];
  logic [DATA_WIDTH-1:0] b_q   [DEPTH];
  logic [DATA_WIDTH-1:0] a_nxt [DEPTH];
  logic [DATA_WIDTH-1:0] b_nxt [DEPTH];

  logic                  out_valid_r;
  logic [OUT_W-1:0]      front_r;
  logic [OUT_W-1:0]      back_r;
  logic [CNT_W-1:0]      cnt_out_r;
  logic                  empty_r;
  status_t               status_r;

  function automatic logic [OUT_W-1:0] ext_word(input logic [DATA_WIDTH-1:0] w);
    return OUT_W'(signed'(w));
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign push_wide = {{OUT_W{1'b0}}, in_push_value};
  assign word      = push_wide[DATA_WIDTH-1:0];

  // a: cell 0 is the front; b: cell 0 is the back
  always_comb begin
    ctrl.a_op = CELL_HOLD;
    ctrl.b_op = CELL_HOLD;
    count_nxt = count_r;
    status    = ST_OK;
    have_pop  = 1'b0;
    popped    = a_q[0];
    case (in_cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.a_op = CELL_SHIFT_IN;
          ctrl.b_op = CELL_LOAD;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.a_op = CELL_LOAD;
          ctrl.b_op = CELL_SHIFT_IN;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.a_op = CELL_SHIFT_OUT;
          count_nxt = count_r - 1'b1;
          have_pop  = 1'b1;
          popped    = a_q[0];
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.b_op = CELL_SHIFT_OUT;
          count_nxt = count_r - 1'b1;
          have_pop  = 1'b1;
          popped    = b_q[0];
        end
      end
      default: begin
        if (empty) begin
          status = ST_EMPTY;
        end
      end
    endcase
    if (!fire) begin
      ctrl.a_op = CELL_HOLD;
      ctrl.b_op = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] a_left, b_left, a_right, b_right;
    if (i == 0) begin : g_first
      assign a_left = word;
      assign b_left = word;
    end else begin : g_mid
      assign a_left = a_q[i-1];
      assign b_left = b_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign a_right = a_q[i];
      assign b_right = b_q[i];
    end else begin : g_inner
      assign a_right = a_q[i+1];
      assign b_right = b_q[i+1];
    end
    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .count   (count_r),
      .word    (word),
      .a_left  (a_left),
      .a_right (a_right),
      .b_left  (b_left),
      .b_right (b_right),
      .a_q     (a_q[i]),
      .b_q     (b_q[i]),
      .a_nxt   (a_nxt[i]),
      .b_nxt   (b_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      if (have_pop) begin
        front_r <= ext_word(popped);
      end else begin
        front_r <= (count_nxt == '0) ? '0 : ext_word(a_nxt[0]);
      end
      back_r    <= (count_nxt == '0) ? '0 : ext_word(b_nxt[0]);
      cnt_out_r <= count_nxt;
      empty_r   <= (count_nxt == '0);
      status_r  <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_value = signed'(front_r);
  assign out_back_value  = signed'(back_r);
  assign out_count       = cnt_out_r;
  assign out_is_empty    = empty_r;
  assign out_status      = status_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && full && (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_PUSH_BACK))
    |=> (out_status == ST_FULL) && $stable(count_r))
    else $error("push into full deque not dropped");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !empty && (in_cmd == CMD_POP_FRONT || in_cmd == CMD_POP_BACK))
    |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not decrement count");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(count_r))
    else $error("state changed while result stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule
